// ----- rtl/core/sorted_key_run_grouper_core_defines.svh -----
// Shared assertion macros for the run grouper core.
`ifndef SORTED_KEY_RUN_GROUPER_CORE_DEFINES_SVH
`define SORTED_KEY_RUN_GROUPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKRG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("skrg check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("skrg check failed");

`endif

// ----- rtl/core/skrg_pkg.sv -----
package skrg_pkg;

    localparam int KEY_W           = 64;
    localparam int POS_W           = 32;
    localparam int CNT_W           = 32;
    localparam int COL_W           = 3;
    localparam int KIND_W          = 2;
    localparam int DEF_AUX_COLUMNS = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [KIND_W-1:0] KIND_DICT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUX    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTALS = 2'd2;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
        logic             final_item;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  row_key;
        logic [POS_W-1:0]  row_value;
        logic              repeated;
        logic [CNT_W-1:0]  aux_index;
        logic [COL_W-1:0]  column;
        logic [CNT_W-1:0]  dict_rows_total;
        logic [CNT_W-1:0]  aux_rows_total;
        logic              end_of_results;
    } t_out_item;

    // Control part of one queued close command.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             overflow;
        logic             totals;
        logic             last;
    } t_cmd_hdr;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ----- rtl/core/skrg_front.sv -----
module skrg_front #(
    parameter int AUX_COLUMNS = skrg_pkg::DEF_AUX_COLUMNS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_in_valid,
    output logic                                           o_in_ready,
    input  skrg_pkg::t_in_item                             i_in_item,
    input  logic                                           i_q_full,
    output logic                                           o_push,
    output skrg_pkg::t_cmd_hdr                             o_hdr,
    output logic [$clog2(AUX_COLUMNS+1)-1:0]               o_len,
    output logic [AUX_COLUMNS-1:0][skrg_pkg::POS_W-1:0]    o_pos
);
    import skrg_pkg::*;

    localparam int LEN_W = $clog2(AUX_COLUMNS + 1);
    localparam int IDX_W = $clog2(AUX_COLUMNS);

    logic [KEY_W-1:0]                  r_held_key;
    logic                              r_held_valid;
    logic [AUX_COLUMNS-1:0][POS_W-1:0] r_pos;
    logic [LEN_W-1:0]                  r_len;
    logic                              r_ovf;
    logic                              r_fin_pend;

    logic accept;
    logic same_key;

    assign o_in_ready = !r_fin_pend && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign same_key   = r_held_valid && (i_in_item.key == r_held_key);

    // The current run is always what gets queued: either the run closed by a
    // new key, or the run closed by the final beat once that beat is registered and the queue has room.
    assign o_push = (accept && !same_key && r_held_valid) || (r_fin_pend && !i_q_full);
    assign o_len  = r_len;
    assign o_pos  = r_pos;

    always_comb begin
        o_hdr          = '0;
        o_hdr.key      = r_held_key;
        o_hdr.overflow = r_ovf;
        o_hdr.totals   = r_fin_pend;
        o_hdr.last     = r_fin_pend || !i_in_item.final_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_key   <= '0;
            r_held_valid <= 1'b0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_fin_pend   <= 1'b0;
        end else if (r_fin_pend) begin
            if (!i_q_full) begin
                r_held_valid <= 1'b0;
                r_len        <= '0;
                r_ovf        <= 1'b0;
                r_fin_pend   <= 1'b0;
            end
        end else if (accept) begin
            r_fin_pend <= i_in_item.final_item;
            if (same_key) begin
                if (r_len < LEN_W'(AUX_COLUMNS)) begin
                    r_pos[r_len[IDX_W-1:0]] <= i_in_item.position;
                    r_len                   <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else begin
                r_held_key   <= i_in_item.key;
                r_held_valid <= 1'b1;
                r_pos[0]     <= i_in_item.position;
                r_len        <= LEN_W'(1);
                r_ovf        <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/skrg_queue.sv -----
module skrg_queue #(
    parameter int AUX_COLUMNS = skrg_pkg::DEF_AUX_COLUMNS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_push,
    input  skrg_pkg::t_cmd_hdr                             i_hdr,
    input  logic [$clog2(AUX_COLUMNS+1)-1:0]               i_len,
    input  logic [AUX_COLUMNS-1:0][skrg_pkg::POS_W-1:0]    i_pos,
    output logic                                           o_full,
    input  logic                                           i_pop,
    output logic                                           o_valid,
    output skrg_pkg::t_cmd_hdr                             o_hdr,
    output logic [$clog2(AUX_COLUMNS+1)-1:0]               o_len,
    output logic [AUX_COLUMNS-1:0][skrg_pkg::POS_W-1:0]    o_pos
);
    import skrg_pkg::*;

    localparam int LEN_W = $clog2(AUX_COLUMNS + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd_hdr                          r_hdr [QUEUE_DEPTH];
    logic [LEN_W-1:0]                  r_len [QUEUE_DEPTH];
    logic [AUX_COLUMNS-1:0][POS_W-1:0] r_pos [QUEUE_DEPTH];
    logic [PTR_W-1:0]                  r_wr_ptr;
    logic [PTR_W-1:0]                  r_rd_ptr;
    logic [CNT_QW-1:0]                 r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_hdr   = r_hdr[r_rd_ptr];
    assign o_len   = r_len[r_rd_ptr];
    assign o_pos   = r_pos[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_hdr[r_wr_ptr] <= i_hdr;
                r_len[r_wr_ptr] <= i_len;
                r_pos[r_wr_ptr] <= i_pos;
                r_wr_ptr        <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/skrg_back.sv -----
module skrg_back #(
    parameter int AUX_COLUMNS = skrg_pkg::DEF_AUX_COLUMNS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic [skrg_pkg::POS_W-1:0]                     i_marker,
    input  logic                                           i_q_valid,
    input  skrg_pkg::t_cmd_hdr                             i_hdr,
    input  logic [$clog2(AUX_COLUMNS+1)-1:0]               i_len,
    input  logic [AUX_COLUMNS-1:0][skrg_pkg::POS_W-1:0]    i_pos,
    output logic                                           o_pop,
    output logic                                           o_out_valid,
    input  logic                                           i_out_ready,
    output skrg_pkg::t_out_item                            o_out_item
);
    import skrg_pkg::*;

    localparam int LEN_W = $clog2(AUX_COLUMNS + 1);
    localparam int IDX_W = $clog2(AUX_COLUMNS);

    typedef enum logic [1:0] {
        S_ROW,
        S_AUX,
        S_TOT
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_dict_cnt, n_dict_cnt;
    logic [CNT_W-1:0] r_aux_cnt, n_aux_cnt;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic out_free;
    logic unique_run;

    assign out_free    = !r_out_valid || i_out_ready;
    assign unique_run  = (i_len <= LEN_W'(1)) && !i_hdr.overflow;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_dict_cnt  = r_dict_cnt;
        n_aux_cnt   = r_aux_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;
        if (out_free && i_q_valid) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            case (r_state)
                S_ROW: begin
                    n_out.kind     = KIND_DICT;
                    n_out.row_key  = i_hdr.key;
                    n_out.repeated = !unique_run;
                    n_dict_cnt     = sat_inc(r_dict_cnt);
                    if (unique_run) begin
                        n_out.row_value = i_pos[0];
                    end else if (i_hdr.overflow) begin
                        n_out.row_value = i_marker;
                    end else begin
                        n_out.row_value = r_aux_cnt;
                        n_col           = '0;
                        n_state         = S_AUX;
                    end
                    if (unique_run || i_hdr.overflow) begin
                        if (i_hdr.totals) begin
                            n_state = S_TOT;
                        end else begin
                            o_pop                = 1'b1;
                            n_out.end_of_results = i_hdr.last;
                        end
                    end
                end
                S_AUX: begin
                    n_out.kind      = KIND_AUX;
                    n_out.row_key   = i_hdr.key;
                    n_out.row_value = (LEN_W'(r_col) < i_len) ? i_pos[r_col] : '0;
                    n_out.repeated  = 1'b1;
                    n_out.aux_index = r_aux_cnt;
                    n_out.column    = COL_W'(r_col);
                    if (r_col == IDX_W'(AUX_COLUMNS - 1)) begin
                        n_aux_cnt = sat_inc(r_aux_cnt);
                        if (i_hdr.totals) begin
                            n_state = S_TOT;
                        end else begin
                            o_pop                = 1'b1;
                            n_out.end_of_results = i_hdr.last;
                            n_state              = S_ROW;
                        end
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                end
                S_TOT: begin
                    n_out.kind            = KIND_TOTALS;
                    n_out.dict_rows_total = r_dict_cnt;
                    n_out.aux_rows_total  = r_aux_cnt;
                    n_out.end_of_results  = i_hdr.last;
                    n_dict_cnt            = '0;
                    n_aux_cnt             = '0;
                    o_pop                 = 1'b1;
                    n_state               = S_ROW;
                end
                default: begin
                    n_out_valid = 1'b0;
                    n_state     = S_ROW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ROW;
            r_col       <= '0;
            r_dict_cnt  <= '0;
            r_aux_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_dict_cnt  <= n_dict_cnt;
            r_aux_cnt   <= n_aux_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

// ----- rtl/core/sorted_key_run_grouper_core.sv -----
// A run closed by a key change is queued as its closing beat is accepted; its row then passes
// through the queue entry and the output register. A run closed by a final beat first waits in r_fin_pend.
// Throughput: one item per cycle while the two-entry queue has room; a repeat run without overflow
// takes 1 + AUX_COLUMNS output beats, and a final beat holds the input until its run is queued.
// Reset is synchronous, active low: it clears the open run, counters and queue and sets the
// ambiguity marker to all ones; run position storage is not cleared.
module sorted_key_run_grouper_core #(
    parameter int AUX_COLUMNS = skrg_pkg::DEF_AUX_COLUMNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  skrg_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output skrg_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_wr_en,
    input  logic [skrg_pkg::POS_W-1:0]    i_cfg_wr_data
);
    import skrg_pkg::*;

    `include "sorted_key_run_grouper_core_defines.svh"

    localparam int LEN_W = $clog2(AUX_COLUMNS + 1);

    logic [POS_W-1:0]                  r_ambiguous_marker;
    logic                              w_push;
    logic                              w_full;
    logic                              w_pop;
    logic                              w_q_valid;
    t_cmd_hdr                          w_front_hdr;
    t_cmd_hdr                          w_head_hdr;
    logic [LEN_W-1:0]                  w_front_len;
    logic [LEN_W-1:0]                  w_head_len;
    logic [AUX_COLUMNS-1:0][POS_W-1:0] w_front_pos;
    logic [AUX_COLUMNS-1:0][POS_W-1:0] w_head_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambiguous_marker <= '1;
        end else if (i_cfg_wr_en) begin
            r_ambiguous_marker <= i_cfg_wr_data;
        end
    end

    skrg_front #(
        .AUX_COLUMNS (AUX_COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_hdr      (w_front_hdr),
        .o_len      (w_front_len),
        .o_pos      (w_front_pos)
    );

    skrg_queue #(
        .AUX_COLUMNS (AUX_COLUMNS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_hdr   (w_front_hdr),
        .i_len   (w_front_len),
        .i_pos   (w_front_pos),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_hdr   (w_head_hdr),
        .o_len   (w_head_len),
        .o_pos   (w_head_pos)
    );

    skrg_back #(
        .AUX_COLUMNS (AUX_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_marker    (r_ambiguous_marker),
        .i_q_valid   (w_q_valid),
        .i_hdr       (w_head_hdr),
        .i_len       (w_head_len),
        .i_pos       (w_head_pos),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // A closed run must never be offered to a full queue, or it is lost.
    `SKRG_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_push, !w_full)
    // Totals always end the results of the final beat.
    `SKRG_ASSERT_NOW(a_totals_last, i_clk, i_rst_n,
        o_out_valid && (o_out_item.kind == KIND_TOTALS), o_out_item.end_of_results)
    // Auxiliary entries are always marked repeated and never carry totals.
    `SKRG_ASSERT_NOW(a_aux_repeated, i_clk, i_rst_n,
        o_out_valid && (o_out_item.kind == KIND_AUX),
        o_out_item.repeated && (o_out_item.dict_rows_total == '0))

endmodule

// ----- dv/run_grouper_checker.sv -----
// Watches both channels and the marker register of the run grouper, keeps its own
// picture of the open run and the row counters, and checks every result beat in order.
module run_grouper_checker #(
    parameter int AUX_COLUMNS = skrg_pkg::DEF_AUX_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  skrg_pkg::t_in_item         i_in_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  skrg_pkg::t_out_item        i_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [skrg_pkg::POS_W-1:0] i_cfg_wr_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import skrg_pkg::*;

    logic [POS_W-1:0] marker;
    logic [KEY_W-1:0] run_key;
    logic             run_open;
    logic [POS_W-1:0] run_pos [AUX_COLUMNS];
    int               run_len;
    logic             run_over;
    logic [CNT_W-1:0] aux_count;
    logic [CNT_W-1:0] dict_count;

    t_out_item        expected_rows [$];
    int               mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_out_item row_beat(
        logic [KIND_W-1:0] kind, logic [KEY_W-1:0] rkey, logic [POS_W-1:0] rval,
        logic rep, logic [CNT_W-1:0] aux, logic [COL_W-1:0] col,
        logic [CNT_W-1:0] dtot, logic [CNT_W-1:0] atot);
        t_out_item b;
        b.kind            = kind;
        b.row_key         = rkey;
        b.row_value       = rval;
        b.repeated        = rep;
        b.aux_index       = aux;
        b.column          = col;
        b.dict_rows_total = dtot;
        b.aux_rows_total  = atot;
        b.end_of_results  = 1'b0;
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

    // Emits the dictionary row of the open run, and its auxiliary row when it has one.
    function automatic void close_open_run();
        logic [CNT_W-1:0] row_idx;
        logic [POS_W-1:0] cell_val;
        if (!run_open) return;
        if (run_over) begin
            expected_rows.push_back(row_beat(KIND_DICT, run_key, marker, 1'b1, '0, '0, '0, '0));
        end else if (run_len <= 1) begin
            expected_rows.push_back(row_beat(KIND_DICT, run_key, run_pos[0], 1'b0,
                                             '0, '0, '0, '0));
        end else begin
            row_idx = aux_count;
            expected_rows.push_back(row_beat(KIND_DICT, run_key, row_idx, 1'b1, '0, '0, '0, '0));
            for (int c = 0; c < AUX_COLUMNS; c++) begin
                cell_val = (c < run_len) ? run_pos[c] : '0;
                expected_rows.push_back(row_beat(KIND_AUX, run_key, cell_val, 1'b1, row_idx,
                                                 COL_W'(c), '0, '0));
            end
            aux_count = bump(aux_count);
        end
        dict_count = bump(dict_count);
        run_open   = 1'b0;
        run_len    = 0;
        run_over   = 1'b0;
    endfunction

    function automatic void group_item(t_in_item it);
        int        first;
        t_out_item tail;
        first = expected_rows.size();
        if (run_open && it.key == run_key) begin
            if (run_len < AUX_COLUMNS) begin
                run_pos[run_len] = it.position;
                run_len++;
            end else begin
                run_over = 1'b1;
            end
        end else begin
            close_open_run();
            run_key    = it.key;
            run_open   = 1'b1;
            run_pos[0] = it.position;
            run_len    = 1;
            run_over   = 1'b0;
        end
        if (it.final_item) begin
            close_open_run();
            expected_rows.push_back(row_beat(KIND_TOTALS, '0, '0, 1'b0, '0, '0,
                                             dict_count, aux_count));
            dict_count = '0;
            aux_count  = '0;
        end
        if (expected_rows.size() > first) begin
            tail = expected_rows.pop_back();
            tail.end_of_results = 1'b1;
            expected_rows.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: result field %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            marker     = '1;
            run_key    = '0;
            run_open   = 1'b0;
            run_len    = 0;
            run_over   = 1'b0;
            aux_count  = '0;
            dict_count = '0;
            for (int c = 0; c < AUX_COLUMNS; c++) run_pos[c] = '0;
            expected_rows.delete();
        end else begin
            // A result beat accepted at this edge always comes from an earlier item.
            if (i_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, i_out_item);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("kind", 64'(want.kind), 64'(i_out_item.kind));
                    check_field("row_key", want.row_key, i_out_item.row_key);
                    check_field("row_value", 64'(want.row_value), 64'(i_out_item.row_value));
                    check_field("repeated", 64'(want.repeated), 64'(i_out_item.repeated));
                    check_field("aux_index", 64'(want.aux_index), 64'(i_out_item.aux_index));
                    check_field("column", 64'(want.column), 64'(i_out_item.column));
                    check_field("dict_rows_total", 64'(want.dict_rows_total),
                                64'(i_out_item.dict_rows_total));
                    check_field("aux_rows_total", 64'(want.aux_rows_total),
                                64'(i_out_item.aux_rows_total));
                    check_field("end_of_results", 64'(want.end_of_results),
                                64'(i_out_item.end_of_results));
                end
            end
            if (i_in_valid && i_in_ready) group_item(i_in_item);
            if (i_cfg_wr_en) marker = i_cfg_wr_data;
        end
        o_pending    <= expected_rows.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;
    import skrg_pkg::*;

    localparam int AUX        = DEF_AUX_COLUMNS;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_item;
    logic             cfg_wr_en;
    logic [POS_W-1:0] cfg_wr_data;

    int               fail_count;
    int               pending;
    int               burst_left = 0;
    bit               hold_req = 0;
    t_in_item         plan [$];

    sorted_key_run_grouper_core #(.AUX_COLUMNS(AUX)) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    run_grouper_checker #(.AUX_COLUMNS(AUX)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_in_item in_beat(logic [KEY_W-1:0] k, logic [POS_W-1:0] p, logic fin);
        t_in_item it;
        it.key        = k;
        it.position   = p;
        it.final_item = fin;
        return it;
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly sorted runs of random length; a few unsorted keys, key reuse across a
    // totals beat, and stray final items that cut a run short.
    function automatic void plan_runs(int count);
        logic [KEY_W-1:0] k;
        int               pick;
        int               run;
        logic             fin;
        k = any_key() >> $urandom_range(1, 40);
        while (count > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      run = 1;
            else if (pick < 85) run = $urandom_range(2, AUX);
            else if (pick < 95) run = $urandom_range(AUX + 1, AUX + 3);
            else                run = 1;
            pick = $urandom_range(0, 9);
            if (pick == 0)      k = any_key();
            else if (pick != 1) k = k + KEY_W'($urandom_range(1, 65536));
            for (int i = 0; i < run && count > 0; i++) begin
                count--;
                fin = (count == 0) || ($urandom_range(0, 49) == 0);
                plan.push_back(in_beat(k, $urandom(), fin));
            end
        end
    endfunction

    // Sends the planned beats in bursts and waits until every result has come back.
    task automatic run_plan();
        for (int i = 0; i < plan.size(); i++) begin
            in_item  <= plan[i];
            in_valid <= 1'b1;
            do @(posedge clk); while (!in_ready);
            if (i == plan.size() - 1) begin
                in_valid <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 15);
            end
        end
        plan.delete();
        do @(posedge clk); while (pending != 0);
        // An item that only extends a run leaves no result, so give the pipe time to settle.
        repeat (8) @(posedge clk);
    endtask

    task automatic write_marker(logic [POS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: segments of differing stall patterns, plus one long hold-off on request
    // that starts once it is asked for.
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        bit       hold_done;
        int       tick;
        out_ready = 1'b0;
        hold_done = 0;
        tick      = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                if (hold_req && !hold_done) begin
                    hold_done = 1;
                    repeat (LONG_HOLD) begin
                        @(posedge clk);
                        out_ready <= 1'b0;
                    end
                end
                @(posedge clk);
                tick++;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= tick[1];
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] k1, k2, k3, k4, k5;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme keys and positions, a pair, a full row, an overlong run
        // under the reset marker, a final beat alone, a key reused after totals, and
        // a final beat that extends a run.
        k1 = 64'h0123_4567_89AB_CDEF;
        k2 = 64'h8000_0000_0000_0000;
        k3 = 64'hA5A5_5A5A_0F0F_F0F0;
        k4 = 64'hFFFF_FFFF_FFFF_FFFE;
        k5 = 64'h0000_0000_0000_0001;
        plan.push_back(in_beat('0, '0, 1'b0));
        plan.push_back(in_beat('1, '1, 1'b0));
        plan.push_back(in_beat(k1, 32'h0000_0001, 1'b0));
        plan.push_back(in_beat(k1, 32'hFFFF_FFFE, 1'b0));
        for (int i = 0; i < AUX; i++) plan.push_back(in_beat(k2, $urandom(), 1'b0));
        for (int i = 0; i <= AUX; i++) plan.push_back(in_beat(k3, $urandom(), 1'b0));
        plan.push_back(in_beat(k4, 32'h8000_0000, 1'b1));
        plan.push_back(in_beat(k4, 32'h7FFF_FFFF, 1'b1));
        plan.push_back(in_beat(k5, $urandom(), 1'b0));
        plan.push_back(in_beat(k5, $urandom(), 1'b1));
        run_plan();

        write_marker('0);
        plan_runs(100);
        run_plan();

        // The receiver holds off for a long stretch while items keep coming.
        write_marker($urandom());
        hold_req = 1;
        plan_runs(100);
        run_plan();

        write_marker('1);
        plan_runs(100);
        run_plan();

        write_marker($urandom());
        plan_runs(100);
        run_plan();

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
